// File: design/least_loaded_server_picker_unit_assert.svh
// Assertion macros shared by the least loaded server picker.
// Each macro expands to one labeled concurrent assertion; no other dependencies.
`ifndef LEAST_LOADED_SERVER_PICKER_UNIT_ASSERT_SVH
`define LEAST_LOADED_SERVER_PICKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LLSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LLSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/llsp_pkg.sv
// Shared types and constants of the least loaded server picker.
// Used by the load cell and by the top level; no dependencies.
package llsp_pkg;

    localparam int DEF_MAX_SERVERS  = 16;
    localparam int MAX_SERVERS_HIGH = 64;
    localparam int LOAD_W           = 32;
    localparam int JOB_W            = 16;
    localparam int ID_W             = 5;
    localparam int CFG_W            = 5;
    localparam int TOK_IDX_W        = $clog2(MAX_SERVERS_HIGH);
    localparam int CNT_W            = $clog2(MAX_SERVERS_HIGH + 1);

    // Running minimum that travels down the row of cells during a scan.
    typedef struct packed {
        logic                 active;
        logic                 best_valid;
        logic [LOAD_W-1:0]    best_load;
        logic [TOK_IDX_W-1:0] best_idx;
        logic                 sec_valid;
        logic [LOAD_W-1:0]    sec_load;
        logic [TOK_IDX_W-1:0] sec_idx;
    } scan_tok_t;

    // Broadcast command from the sequencer to every cell.
    typedef struct packed {
        logic                 clear;
        logic                 wr_en;
        logic [TOK_IDX_W-1:0] wr_idx;
        logic [LOAD_W-1:0]    wr_data;
    } cell_cmd_t;

endpackage

// File: design/llsp_cell.sv
// One server slot of the picker: holds that server's load and folds it into
// the passing scan word. Depends on llsp_pkg.
module llsp_cell
    import llsp_pkg::*;
#(
    parameter int CELL_ID = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [CNT_W-1:0] n_used,
    input  scan_tok_t        tok_in,
    output scan_tok_t        tok_out
);

    logic [LOAD_W-1:0] load_reg;
    logic [LOAD_W-1:0] load_next;
    scan_tok_t         tok_reg;
    scan_tok_t         tok_next;

    always_comb
    begin
        load_next = load_reg;
        if (cmd.clear)
        begin
            load_next = '0;
        end
        else if (cmd.wr_en && (cmd.wr_idx == TOK_IDX_W'(CELL_ID)))
        begin
            load_next = cmd.wr_data;
        end
    end

    // Best and second best are kept; cells visit in id order, so strict
    // compares keep the lowest id on ties.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && (CNT_W'(CELL_ID) < n_used))
        begin
            if (!tok_in.best_valid)
            begin
                tok_next.best_valid = 1'b1;
                tok_next.best_load  = load_reg;
                tok_next.best_idx   = TOK_IDX_W'(CELL_ID);
            end
            else if (load_reg < tok_in.best_load)
            begin
                tok_next.sec_valid  = 1'b1;
                tok_next.sec_load   = tok_in.best_load;
                tok_next.sec_idx    = tok_in.best_idx;
                tok_next.best_load  = load_reg;
                tok_next.best_idx   = TOK_IDX_W'(CELL_ID);
            end
            else if (!tok_in.sec_valid || (load_reg < tok_in.sec_load))
            begin
                tok_next.sec_valid  = 1'b1;
                tok_next.sec_load   = load_reg;
                tok_next.sec_idx    = TOK_IDX_W'(CELL_ID);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            load_reg <= load_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: design/least_loaded_server_picker_unit.sv
// Least loaded server picker: a row of MAX_SERVERS load cells and a sequencer.
// With the result side ready, a job that opens a server while more remain closed goes
// from accept through decide to result; otherwise a scan of the row comes before the result.
// A new job word is taken only in the idle state, after the result of the last one is presented.
// Reset clears all loads and the open count and sets num_servers to 1.
module least_loaded_server_picker_unit
    import llsp_pkg::*;
#(
    parameter int MAX_SERVERS = DEF_MAX_SERVERS
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Job words.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,    // [15:0] job_time
    input  logic             s_tuser,    // [0] first_of_case
    // Result words.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,    // [4:0] assigned_server, [9:5] next_server
    // Configuration write.
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data    // [4:0] num_servers
);

`include "least_loaded_server_picker_unit_assert.svh"

    localparam int CW = $clog2(MAX_SERVERS + 1);
    localparam int NW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  cfg_reg, cfg_next;
    logic [JOB_W-1:0]  job_reg, job_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     opened_reg, opened_next;
    logic [CW-1:0]     id_reg, id_next;
    logic [CW-1:0]     nxt_reg, nxt_next;
    logic              pick_reg, pick_next;
    logic              inject_reg, inject_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;

    logic              s_accept;
    logic [NW-1:0]     cfg_wide;
    logic [CW-1:0]     n_eff;
    logic [CW:0]       opened_inc;
    logic [CW:0]       opened_inc2;
    logic [CW-1:0]     k_id;
    logic [CW-1:0]     sec_id;
    logic [LOAD_W:0]   sum_wide;
    logic [LOAD_W-1:0] sum_sat;
    cell_cmd_t         cmd;
    scan_tok_t         tok [MAX_SERVERS+1];
    scan_tok_t         tail;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Server count out of range is clamped to 1..MAX_SERVERS.
    always_comb
    begin
        cfg_wide = NW'(cfg_reg);
        if (cfg_wide == '0)
        begin
            n_eff = CW'(1);
        end
        else if (cfg_wide > NW'(MAX_SERVERS))
        begin
            n_eff = CW'(MAX_SERVERS);
        end
        else
        begin
            n_eff = CW'(cfg_wide);
        end
    end

    // The row of cells; the scan word enters at cell 0.
    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = inject_reg;
    end

    for (genvar g = 0; g < MAX_SERVERS; g++)
    begin : g_cell
        llsp_cell #(
            .CELL_ID (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .n_used  (CNT_W'(n_reg)),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign tail        = tok[MAX_SERVERS];
    assign opened_inc  = {1'b0, opened_reg} + (CW+1)'(1);
    assign opened_inc2 = {1'b0, opened_reg} + (CW+1)'(2);
    assign k_id        = CW'(tail.best_idx) + CW'(1);
    assign sec_id      = CW'(tail.sec_idx) + CW'(1);
    assign sum_wide    = {1'b0, tail.best_load} + (LOAD_W+1)'(job_reg);
    assign sum_sat     = sum_wide[LOAD_W] ? '1 : sum_wide[LOAD_W-1:0];

    always_comb
    begin
        cmd         = '0;
        cmd.clear   = s_accept && s_tuser;
        state_next  = state_reg;
        cfg_next    = cfg_reg;
        job_next    = job_reg;
        n_next      = n_reg;
        opened_next = opened_reg;
        id_next     = id_reg;
        nxt_next    = nxt_reg;
        pick_next   = pick_reg;
        inject_next = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (cfg_valid && cfg_ready)
        begin
            cfg_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    job_next   = s_tdata[JOB_W-1:0];
                    n_next     = n_eff;
                    state_next = ST_DECIDE;
                    if (s_tuser)
                    begin
                        opened_next = '0;
                    end
                end
            end
            ST_DECIDE:
            begin
                if (opened_reg < n_reg)
                begin
                    // Open the next server with this job's time as its load.
                    cmd.wr_en   = 1'b1;
                    cmd.wr_idx  = TOK_IDX_W'(opened_reg);
                    cmd.wr_data = LOAD_W'(job_reg);
                    opened_next = opened_inc[CW-1:0];
                    id_next     = opened_inc[CW-1:0];
                    if (opened_inc < {1'b0, n_reg})
                    begin
                        nxt_next   = opened_inc2[CW-1:0];
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        pick_next   = 1'b0;
                        inject_next = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
                else
                begin
                    pick_next   = 1'b1;
                    inject_next = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.active)
                begin
                    state_next = ST_RESULT;
                    if (pick_reg)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_idx  = tail.best_idx;
                        cmd.wr_data = sum_sat;
                        id_next     = k_id;
                        // Only the picked load changed: the next pick is it or
                        // the runner-up, lowest id on a tie.
                        if (!tail.sec_valid || (sum_sat < tail.sec_load))
                        begin
                            nxt_next = k_id;
                        end
                        else if (sum_sat == tail.sec_load)
                        begin
                            nxt_next = (tail.best_idx < tail.sec_idx) ? k_id : sec_id;
                        end
                        else
                        begin
                            nxt_next = sec_id;
                        end
                    end
                    else
                    begin
                        nxt_next = k_id;
                    end
                end
            end
            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, ID_W'(nxt_reg), ID_W'(id_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= CFG_W'(1);
            opened_reg   <= '0;
            pick_reg     <= 1'b0;
            inject_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cfg_reg      <= cfg_next;
            opened_reg   <= opened_next;
            pick_reg     <= pick_next;
            inject_reg   <= inject_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        n_reg       <= n_next;
        id_reg      <= id_next;
        nxt_reg     <= nxt_next;
        m_tdata_reg <= m_tdata_next;
    end

    `LLSP_ASSERT_NOW(a_open_bound, clk, rst_n, 1'b1, opened_reg <= CW'(MAX_SERVERS), "open count past server limit")
    `LLSP_ASSERT_NOW(a_tail_in_scan, clk, rst_n, tail.active, state_reg == ST_SCAN, "scan word left the row outside a scan")
    `LLSP_ASSERT_NOW(a_tail_has_min, clk, rst_n, tail.active, tail.best_valid, "scan finished without a minimum")
    `LLSP_ASSERT_NEXT(a_accept_decide, clk, rst_n, s_accept, state_reg == ST_DECIDE, "accepted job not taken to decision")
    `LLSP_ASSERT_NEXT(a_result_out, clk, rst_n, (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready), m_tvalid_reg && (state_reg == ST_IDLE), "result not presented")

endmodule
